// ===== src/lnts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_pkg
// shared types, constants and helpers of the lcd nibble task sequencer
// ----------------------------------------------------------------------------
package lnts_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  // task kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_BUSY  = 2'd3;

  // phases
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  // bit of the task word that drives register select
  localparam int RS_BIT = 9;

  // item kinds on func
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [1:0]  phase;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       enable;
  } pins_t;

  typedef struct packed {
    entry_t entry;
    pins_t  pins;
    logic   pop;
  } step_t;

  // ring increment, wraps at the queue depth
  function automatic idx_t next_slot(input idx_t i);
    idx_t n;
    if (i == idx_t'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + idx_t'(1);
    end
    return n;
  endfunction

endpackage

// ===== src/lnts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lnts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lnts_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_step
// one tick of the head task: next entry, next pin levels and pop flag
// ----------------------------------------------------------------------------
module lnts_step (
  input  lnts_pkg::entry_t cur,
  input  lnts_pkg::pins_t  pins,
  output lnts_pkg::step_t  step
);

  always_comb begin
    step.entry = cur;
    step.pins  = pins;
    step.pop   = 1'b0;
    case (cur.kind)
      lnts_pkg::KIND_WAIT: begin
        if (cur.data == 16'd0) begin
          step.pop = 1'b1;
        end else begin
          step.entry.data = cur.data - 16'd1;
        end
      end
      lnts_pkg::KIND_WRITE: begin
        case (cur.phase)
          lnts_pkg::PH_0: begin
            step.pins.rs      = cur.data[lnts_pkg::RS_BIT];
            step.pins.nibble  = cur.data[7:4];
            step.pins.enable  = 1'b1;
            step.entry.phase  = lnts_pkg::PH_1;
          end
          lnts_pkg::PH_1: begin
            step.pins.enable  = 1'b0;
            step.entry.phase  = lnts_pkg::PH_2;
          end
          lnts_pkg::PH_2: begin
            step.pins.rs      = cur.data[lnts_pkg::RS_BIT];
            step.pins.nibble  = cur.data[3:0];
            step.pins.enable  = 1'b1;
            step.entry.phase  = lnts_pkg::PH_3;
          end
          default: begin
            step.pins.enable  = 1'b0;
            step.pop          = 1'b1;
          end
        endcase
      end
      lnts_pkg::KIND_BUSY: begin
        case (cur.phase)
          lnts_pkg::PH_0: begin
            step.pins.rs      = 1'b0;
            step.pins.nibble  = 4'd0;
            step.pins.enable  = 1'b1;
            step.entry.phase  = lnts_pkg::PH_1;
          end
          lnts_pkg::PH_1: begin
            step.pins.enable  = 1'b0;
            step.entry.phase  = lnts_pkg::PH_2;
          end
          lnts_pkg::PH_2: begin
            step.pins.enable  = 1'b1;
            step.entry.phase  = lnts_pkg::PH_3;
          end
          default: begin
            step.pins.enable  = 1'b0;
            step.pop          = 1'b1;
          end
        endcase
      end
      default: begin
        // no task: just pop
        step.pop = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/lcd_nibble_task_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_task_sequencer_core
// ring queue of lcd tasks driving a character display in 4-bit mode
// ----------------------------------------------------------------------------
// Each input word is either a push (func 0) that appends a task after the tail
// or a tick (func 1) that runs one step of the task at the head; every word
// yields exactly one result word with the rs, nibble and enable pin levels and
// the queue idle flag. Tasks live in a 64-entry ram with a registered read; a
// push writes its entry directly, while a tick reads the head entry from the
// ram, then modifies and writes it back, and when a pop moves the head onto the
// tail it also reads the new head entry to decide the idle flag. The queue has
// no full check: pushing past the depth overwrites the oldest entries. A bank
// of per-entry valid flags is cleared by reset, so the queue is usable at once
// with no clearing pass; an entry whose flag is low reads as no task.
// ----------------------------------------------------------------------------
module lcd_nibble_task_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [1:0]  command,
  input  logic [15:0] task_data,
  input  logic [1:0]  start_phase,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        lcd_rs,
  output logic [3:0]  lcd_nibble,
  output logic        lcd_enable,
  output logic        queue_idle
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a word
  localparam logic [1:0] ST_EXEC  = 2'd1;  // head entry read, run one step
  localparam logic [1:0] ST_CHECK = 2'd2;  // new head entry read, idle flag

  logic [1:0]                          state;
  lnts_pkg::idx_t                      head;
  lnts_pkg::idx_t                      tail;
  lnts_pkg::pins_t                     pins;
  logic [lnts_pkg::QUEUE_DEPTH-1:0]    valid;

  logic                                accept;
  lnts_pkg::idx_t                      tail_adv;
  lnts_pkg::idx_t                      head_adv;

  // task ram ports
  logic                                ram_we;
  lnts_pkg::idx_t                      ram_waddr;
  logic [lnts_pkg::ENTRY_W-1:0]        ram_wdata;
  lnts_pkg::idx_t                      ram_raddr;
  logic [lnts_pkg::ENTRY_W-1:0]        ram_rdata;

  lnts_pkg::entry_t                    cur_entry;
  lnts_pkg::step_t                     step;

  // result loading
  logic                                out_load;
  lnts_pkg::pins_t                     out_pins_d;
  logic                                out_idle_d;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign tail_adv = lnts_pkg::next_slot(tail);
  assign head_adv = lnts_pkg::next_slot(head);

  // head entry as stored, reading as no task when never written or popped
  assign cur_entry = valid[head] ? lnts_pkg::entry_t'(ram_rdata) : '0;

  lnts_ram #(
    .WIDTH (lnts_pkg::ENTRY_W),
    .DEPTH (lnts_pkg::QUEUE_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lnts_step u_step (
    .cur  (cur_entry),
    .pins (pins),
    .step (step)
  );

  // ram access: a push writes at the advanced tail, a step that keeps the
  // task writes it back at the head; reads look at the head, or at the slot
  // after it while a step is running
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head;
    ram_wdata = step.entry;
    ram_raddr = head;
    if (accept && (func == lnts_pkg::FUNC_PUSH)) begin
      ram_we    = 1'b1;
      ram_waddr = tail_adv;
      ram_wdata = {command, task_data, start_phase};
    end else if (state == ST_EXEC) begin
      ram_we    = !step.pop;
      ram_raddr = head_adv;
    end
  end

  // result of the current word, when it is settled this cycle
  always_comb begin
    out_load   = 1'b0;
    out_pins_d = pins;
    out_idle_d = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (func == lnts_pkg::FUNC_PUSH)) begin
          // only when the tail lands on the head does the new task sit there
          out_load   = 1'b1;
          out_idle_d = (tail_adv == head) && (command == lnts_pkg::KIND_NONE);
        end
      end
      ST_EXEC: begin
        out_pins_d = step.pins;
        if (step.pop) begin
          if (head == tail) begin
            // head stays on a freshly cleared entry
            out_load   = 1'b1;
            out_idle_d = 1'b1;
          end else if (head_adv != tail) begin
            out_load   = 1'b1;
            out_idle_d = 1'b0;
          end
        end else begin
          out_load   = 1'b1;
          out_idle_d = (head == tail) && (step.entry.kind == lnts_pkg::KIND_NONE);
        end
      end
      ST_CHECK: begin
        // head now equals tail, the flag follows the new head entry
        out_load   = 1'b1;
        out_idle_d = (cur_entry.kind == lnts_pkg::KIND_NONE);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      pins      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func == lnts_pkg::FUNC_PUSH) begin
              tail            <= tail_adv;
              valid[tail_adv] <= 1'b1;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          pins <= step.pins;
          if (step.pop) begin
            valid[head] <= 1'b0;
            if (head != tail) begin
              head <= head_adv;
              // landing on the tail needs a look at that entry
              state <= (head_adv == tail) ? ST_CHECK : ST_IDLE;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CHECK: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      lcd_rs     <= out_pins_d.rs;
      lcd_nibble <= out_pins_d.nibble;
      lcd_enable <= out_pins_d.enable;
      queue_idle <= out_idle_d;
    end
  end

  // no new word while a tick is in flight
  a_busy_blocks_input : assert property (
    @(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready
  ) else $error("input taken while a tick is in progress");

  // the idle-flag read happens only once the head has met the tail
  a_check_at_tail : assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (head == tail)
  ) else $error("head entry check away from the tail");

  // a step always follows a tick accepted in the idle state
  a_exec_after_tick : assert property (
    @(posedge clk) disable iff (rst)
    (accept && (func == lnts_pkg::FUNC_TICK)) |=> (state == ST_EXEC)
  ) else $error("tick did not start a step");

endmodule
